// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define OWDR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while rst is high.
`define OWDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: rtl/core/owdr_pkg.sv
`default_nettype none

package owdr_pkg;

   // Field widths.
   localparam int RATE_W     = 16;
   localparam int TIME_W     = 16;
   localparam int ANG_W      = 16;
   localparam int POS_W      = 32;
   localparam int VEL_W      = 18;
   localparam int TRIG_W     = 17;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 120;

   // Register file.
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_A    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_B    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_C    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_TIME = 8'd3;
   localparam logic [TIME_W-1:0]      STEP_TIME_RESET = 16'd655;

   // Shared multiplier: signed 35 x signed 17.
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Heading gain round(2^32 / (2*pi)), split into two 15-bit halves.
   localparam logic [29:0] HEAD_K    = 30'd683565276;
   localparam logic [14:0] HEAD_K_LO = HEAD_K[14:0];
   localparam logic [14:0] HEAD_K_HI = HEAD_K[29:15];

   // CORDIC constants, angles in binary-angle units.
   localparam int CORDIC_STAGES = 14;
   localparam int ITER_W        = $clog2(CORDIC_STAGES);
   localparam int CORDIC_XY_W   = 18;
   localparam int CORDIC_Z_W    = 17;
   localparam int ATAN_W        = 14;
   localparam logic signed [CORDIC_XY_W-1:0] CORDIC_GAIN = 18'sd9949;
   localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
      14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163,
      14'd81, 14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1
   };

   // Wheel mounting offsets: one third and two thirds of a turn.
   localparam logic [ANG_W-1:0] THIRD_TURN      = 16'd21845;
   localparam logic [ANG_W-1:0] TWO_THIRDS_TURN = 16'd43691;

   // Request and response of the sine/cosine unit.
   typedef struct packed {
      logic             start;
      logic [ANG_W-1:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [TRIG_W-1:0] cos;
      logic signed [TRIG_W-1:0] sin;
   } cordic_rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/owdr_cordic.sv
`default_nettype none

module owdr_cordic (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire owdr_pkg::cordic_req_type cordic_req,
   output owdr_pkg::cordic_rsp_type     cordic_rsp
);
   import owdr_pkg::*;

   logic signed [CORDIC_XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CORDIC_Z_W-1:0]  z_ff, z_in;
   logic [ITER_W-1:0]             iter_ff, iter_in;
   logic                          busy_ff, busy_in;
   logic                          flip_ff, flip_in;
   logic                          done_ff, done_in;
   logic signed [TRIG_W-1:0]      cos_ff, cos_in, sin_ff, sin_in;

   logic signed [CORDIC_XY_W-1:0] dx, dy, x_step, y_step, x_fin, y_fin;
   logic signed [CORDIC_Z_W-1:0]  atan_val, z_step;
   logic                          z_neg, last_iter, flip_req;
   logic [ANG_W-1:0]              angle_turned;

   // One rotation stage per cycle through the shared shifter and adders.
   always_comb begin
      dx        = y_ff >>> iter_ff;
      dy        = x_ff >>> iter_ff;
      atan_val  = signed'({3'b000, ATAN_TAB[iter_ff]});
      z_neg     = z_ff[CORDIC_Z_W-1];
      x_step    = z_neg ? (x_ff + dx) : (x_ff - dx);
      y_step    = z_neg ? (y_ff - dy) : (y_ff + dy);
      z_step    = z_neg ? (z_ff + atan_val) : (z_ff - atan_val);
      x_fin     = flip_ff ? -x_step : x_step;
      y_fin     = flip_ff ? -y_step : y_step;
      last_iter = (iter_ff == ITER_W'(CORDIC_STAGES - 1));
   end

   // Angles in the left half-plane are turned by a half turn first.
   assign flip_req     = cordic_req.angle[ANG_W-1] ^ cordic_req.angle[ANG_W-2];
   assign angle_turned = {cordic_req.angle[ANG_W-1] ^ flip_req, cordic_req.angle[ANG_W-2:0]};

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      done_in = 1'b0;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (cordic_req.start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = CORDIC_Z_W'(signed'(angle_turned));
         iter_in = '0;
         busy_in = 1'b1;
         flip_in = flip_req;
      end else if (busy_ff) begin
         x_in    = x_step;
         y_in    = y_step;
         z_in    = z_step;
         iter_in = iter_ff + 1'b1;
         if (last_iter) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cos_in  = x_fin[TRIG_W-1:0];
            sin_in  = y_fin[TRIG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      flip_ff <= flip_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign cordic_rsp.done = done_ff;
   assign cordic_rsp.cos  = cos_ff;
   assign cordic_rsp.sin  = sin_ff;

endmodule

`default_nettype wire

// File: rtl/core/omni_wheel_dead_reckoning.sv
// A step request first updates the heading and the position; a start request
// clears the pose. Both then run each wheel through the iterative CORDIC and the
// shared 35x17 multiplier and write the result, with one request in flight at a time.
// The result waits while the output register is still full.
// Synchronous active-high reset clears the pose, the velocity, the wheel rates
// and sets the step time to 655; the block is ready in the first cycle after.
`default_nettype none

module omni_wheel_dead_reckoning (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel. tdata: [0] start_req, [7:1] zero.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [owdr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Result channel. tdata: [31:0] pos_x, [63:32] pos_y, [79:64] heading,
   // [97:80] vel_x, [115:98] vel_y, [119:116] zero.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [owdr_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // Register write channel.
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [owdr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [owdr_pkg::CSR_DATA_W-1:0]   csr_data
);
   import owdr_pkg::*;

   localparam int HEAD_ACC_W = 56;
   localparam int POS_SUM_W  = 34;
   localparam int ACC_W      = 36;
   localparam int VEL_SUM_W  = 24;
   localparam logic signed [HEAD_ACC_W-1:0] HEAD_ROUND = 56'sh80_0000_0000;
   localparam logic signed [POS_SUM_W-1:0]  POS_MAX = 34'sd2147483647;
   localparam logic signed [POS_SUM_W-1:0]  POS_MIN = -34'sd2147483648;
   localparam logic signed [VEL_SUM_W-1:0]  VEL_MAX = 24'sd131071;
   localparam logic signed [VEL_SUM_W-1:0]  VEL_MIN = -24'sd131072;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_Q, ST_MUL_KL, ST_MUL_KH, ST_HEAD_ADD, ST_POS_X, ST_POS_Y,
      ST_ROT_START, ST_ROT_WAIT, ST_MUL_COS, ST_MUL_SIN, ST_ACC_SIN, ST_FINISH
   } state_type;

   state_type                      state_ff, state_in;
   logic signed [RATE_W-1:0]       rate_a_ff, rate_a_in, rate_b_ff, rate_b_in;
   logic signed [RATE_W-1:0]       rate_c_ff, rate_c_in;
   logic [TIME_W-1:0]              step_time_ff, step_time_in;
   logic signed [POS_W-1:0]        pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [ANG_W-1:0]               heading_ff, heading_in;
   logic signed [VEL_W-1:0]        speed_x_ff, speed_x_in, speed_y_ff, speed_y_in;
   logic signed [MUL_A_W-1:0]      q_ff, q_in;
   logic signed [HEAD_ACC_W-1:0]   head_acc_ff, head_acc_in;
   logic signed [ACC_W-1:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic [1:0]                     wheel_ff, wheel_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]          rsp_data_ff, rsp_data_in;

   logic signed [MUL_A_W-1:0]      mul_a;
   logic signed [MUL_B_W-1:0]      mul_b;
   logic signed [VEL_W:0]          rate_sum;
   logic signed [RATE_W-1:0]       rate_sel;
   logic [ANG_W-1:0]               wheel_off;
   logic signed [HEAD_ACC_W-1:0]   head_total;
   logic signed [PROD_W-1:0]       pos_round, pos_shift;
   logic signed [POS_SUM_W-1:0]    pos_sum;
   logic signed [POS_W-1:0]        pos_cur, pos_sat;
   logic signed [ACC_W-1:0]        vx_round, vy_round, vx_shift, vy_shift;
   logic signed [VEL_SUM_W-1:0]    vx_sum, vy_sum;
   logic signed [VEL_W-1:0]        vel_x_sat, vel_y_sat;
   logic                           out_free;
   cordic_req_type                 cordic_req;
   cordic_rsp_type                 cordic_rsp;

   owdr_cordic u_cordic (
      .clock      (clock),
      .reset      (reset),
      .cordic_req (cordic_req),
      .cordic_rsp (cordic_rsp)
   );

   // Sum of the three wheel rates and the rate and offset of the current wheel.
   assign rate_sum = (VEL_W+1)'(rate_a_ff) + (VEL_W+1)'(rate_b_ff) + (VEL_W+1)'(rate_c_ff);

   always_comb begin
      case (wheel_ff)
         2'd0: begin
            rate_sel  = rate_a_ff;
            wheel_off = '0;
         end
         2'd1: begin
            rate_sel  = rate_b_ff;
            wheel_off = THIRD_TURN;
         end
         default: begin
            rate_sel  = rate_c_ff;
            wheel_off = TWO_THIRDS_TURN;
         end
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_MUL_Q: begin
            mul_a = MUL_A_W'(rate_sum);
            mul_b = signed'({1'b0, step_time_ff});
         end
         ST_MUL_KL: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = signed'({2'b00, HEAD_K_LO});
         end
         ST_MUL_KH: begin
            mul_a = q_ff;
            mul_b = signed'({2'b00, HEAD_K_HI});
         end
         ST_HEAD_ADD: begin
            mul_a = MUL_A_W'(speed_x_ff);
            mul_b = signed'({1'b0, step_time_ff});
         end
         ST_POS_X: begin
            mul_a = MUL_A_W'(speed_y_ff);
            mul_b = signed'({1'b0, step_time_ff});
         end
         ST_MUL_COS: begin
            mul_a = MUL_A_W'(rate_sel);
            mul_b = cordic_rsp.cos;
         end
         ST_MUL_SIN: begin
            mul_a = MUL_A_W'(rate_sel);
            mul_b = cordic_rsp.sin;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Heading increment: upper bits of the two partial products, rounded.
   assign head_total = head_acc_ff + (HEAD_ACC_W'(prod_ff) <<< 15);

   // Position update: rounded speed times step, saturated to 32 bits.
   always_comb begin
      pos_round = prod_ff + PROD_W'(128);
      pos_shift = pos_round >>> 8;
      pos_cur   = (state_ff == ST_POS_Y) ? pos_y_ff : pos_x_ff;
      pos_sum   = POS_SUM_W'(pos_cur) + pos_shift[POS_SUM_W-1:0];
      if (pos_sum > POS_MAX) begin
         pos_sat = POS_MAX[POS_W-1:0];
      end else if (pos_sum < POS_MIN) begin
         pos_sat = POS_MIN[POS_W-1:0];
      end else begin
         pos_sat = pos_sum[POS_W-1:0];
      end
   end

   // Velocity: rounded sums of the wheel projections, saturated to 18 bits.
   always_comb begin
      vx_round = ax_ff + ACC_W'(8192);
      vy_round = ay_ff + ACC_W'(8192);
      vx_shift = vx_round >>> 14;
      vy_shift = vy_round >>> 14;
      vx_sum   = vx_shift[VEL_SUM_W-1:0];
      vy_sum   = -vy_shift[VEL_SUM_W-1:0];
      if (vx_sum > VEL_MAX) begin
         vel_x_sat = VEL_MAX[VEL_W-1:0];
      end else if (vx_sum < VEL_MIN) begin
         vel_x_sat = VEL_MIN[VEL_W-1:0];
      end else begin
         vel_x_sat = vx_sum[VEL_W-1:0];
      end
      if (vy_sum > VEL_MAX) begin
         vel_y_sat = VEL_MAX[VEL_W-1:0];
      end else if (vy_sum < VEL_MIN) begin
         vel_y_sat = VEL_MIN[VEL_W-1:0];
      end else begin
         vel_y_sat = vy_sum[VEL_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   assign cordic_req.start = (state_ff == ST_ROT_START);
   assign cordic_req.angle = heading_ff + wheel_off;

   // Sequencer and register file.
   always_comb begin
      state_in     = state_ff;
      rate_a_in    = rate_a_ff;
      rate_b_in    = rate_b_ff;
      rate_c_in    = rate_c_ff;
      step_time_in = step_time_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      heading_in   = heading_ff;
      speed_x_in   = speed_x_ff;
      speed_y_in   = speed_y_ff;
      q_in         = q_ff;
      head_acc_in  = head_acc_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      wheel_in     = wheel_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // Register writes.
      if (csr_valid) begin
         case (csr_index)
            REG_RATE_A:    rate_a_in    = signed'(csr_data);
            REG_RATE_B:    rate_b_in    = signed'(csr_data);
            REG_RATE_C:    rate_c_in    = signed'(csr_data);
            REG_STEP_TIME: step_time_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tdata[0]) begin
                  pos_x_in   = '0;
                  pos_y_in   = '0;
                  heading_in = '0;
                  ax_in      = '0;
                  ay_in      = '0;
                  wheel_in   = '0;
                  state_in   = ST_ROT_START;
               end else begin
                  state_in = ST_MUL_Q;
               end
            end
         end
         ST_MUL_Q: begin
            state_in = ST_MUL_KL;
         end
         ST_MUL_KL: begin
            q_in     = prod_ff[MUL_A_W-1:0];
            state_in = ST_MUL_KH;
         end
         ST_MUL_KH: begin
            head_acc_in = HEAD_ACC_W'(prod_ff) + HEAD_ROUND;
            state_in    = ST_HEAD_ADD;
         end
         ST_HEAD_ADD: begin
            heading_in = heading_ff + head_total[HEAD_ACC_W-1:HEAD_ACC_W-ANG_W];
            state_in   = ST_POS_X;
         end
         ST_POS_X: begin
            pos_x_in = pos_sat;
            state_in = ST_POS_Y;
         end
         ST_POS_Y: begin
            pos_y_in = pos_sat;
            ax_in    = '0;
            ay_in    = '0;
            wheel_in = '0;
            state_in = ST_ROT_START;
         end
         ST_ROT_START: begin
            state_in = ST_ROT_WAIT;
         end
         ST_ROT_WAIT: begin
            if (cordic_rsp.done) begin
               state_in = ST_MUL_COS;
            end
         end
         ST_MUL_COS: begin
            state_in = ST_MUL_SIN;
         end
         ST_MUL_SIN: begin
            ax_in    = ax_ff + ACC_W'(prod_ff);
            state_in = ST_ACC_SIN;
         end
         ST_ACC_SIN: begin
            ay_in = ay_ff + ACC_W'(prod_ff);
            if (wheel_ff == 2'd2) begin
               state_in = ST_FINISH;
            end else begin
               wheel_in = wheel_ff + 1'b1;
               state_in = ST_ROT_START;
            end
         end
         ST_FINISH: begin
            // Wait here until the output register is free.
            if (out_free) begin
               speed_x_in   = vel_x_sat;
               speed_y_in   = vel_y_sat;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, vel_y_sat, vel_x_sat, heading_ff, pos_y_ff, pos_x_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      head_acc_ff <= head_acc_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_a_ff    <= '0;
         rate_b_ff    <= '0;
         rate_c_ff    <= '0;
         step_time_ff <= STEP_TIME_RESET;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         speed_x_ff   <= '0;
         speed_y_ff   <= '0;
         wheel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_a_ff    <= rate_a_in;
         rate_b_ff    <= rate_b_in;
         rate_c_ff    <= rate_c_in;
         step_time_ff <= step_time_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         speed_x_ff   <= speed_x_in;
         speed_y_ff   <= speed_y_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire

// File: rtl/core/owdr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module owdr_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready
);

   // An accepted request keeps the block busy for the following cycle.
   `OWDR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // A result is held until it is taken.
   `OWDR_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // Reset leaves no result pending and the block ready for a request.
   `OWDR_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_tvalid && req_tready)

   // A new result only comes out of a request that was being worked on.
   `OWDR_ASSERT_IMP(a_rsp_from_work, clock, reset, $rose(rsp_tvalid), $past(!req_tready))

endmodule

bind omni_wheel_dead_reckoning owdr_checker u_owdr_checker (.*);

`default_nettype wire
